// ===== rtl/flba_pkg.sv =====
// ----------------------------------------------------------------------------
// flba_pkg
// Types and codes shared by the free-list buffer allocator modules.
// ----------------------------------------------------------------------------
package flba_pkg;

    localparam int unsigned IDX_W = 10;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_FOREIGN = 2'd2,
        STATUS_IDLE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] node_index;
    } t_request;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] granted_index;
        logic [IDX_W-1:0] free_count;
    } t_result;

    // slot memory access request: one read and one write
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_busy;
        logic [IDX_W-1:0] wr_link;
    } t_mem_req;

endpackage

// ===== rtl/flba_mem.sv =====
// ----------------------------------------------------------------------------
// flba_mem
// Slot memory: one in-use mark and one next link per slot, one write port
// and one read port, read data registered.
// ----------------------------------------------------------------------------
module flba_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic                             i_clk,
    input  flba_pkg::t_mem_req               i_req,
    output logic                             o_rd_busy,
    output logic [flba_pkg::IDX_W-1:0]       o_rd_link
);

    logic [AW:0] r_mem [DEPTH];
    logic [AW:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= {i_req.wr_busy, i_req.wr_link[AW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_busy = r_rd_data[AW];
    assign o_rd_link = flba_pkg::IDX_W'(r_rd_data[AW-1:0]);

endmodule

// ===== rtl/free_list_buffer_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_buffer_allocator
// LIFO free-list allocator over a fixed pool of CAPACITY buffer slots.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. An acquire pops
// the head of the free list and hands out that slot; a release checks that
// the slot belongs to the pool and is in use, then pushes it back. Each
// transaction gives exactly one result on o_result, shown for one cycle with
// o_done high; the receiver cannot stall it, so it must sample o_result
// whenever o_done is high. Every transaction is taken in idle and then passes
// an execute state: the per-slot link and in-use mark live in a single-port-read
// memory with registered read data, and the pop needs the link of the head slot
// before the next head is known. A new transaction may start in the cycle its
// predecessor's result is shown. After reset, busy stays high while the slot
// memory is swept to build the initial list (slot i links to i-1, head is slot
// CAPACITY-1, nothing in use).
// ----------------------------------------------------------------------------
module free_list_buffer_allocator #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  flba_pkg::t_request i_req,
    output logic               o_done,
    output flba_pkg::t_result  o_result
);

    // slot index width and count width
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = flba_pkg::IDX_W;

    // control state
    flba_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_init_addr;

    // list state
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;

    // captured transaction
    flba_pkg::t_op    r_op;
    logic [IW-1:0]    r_idx;

    // result register
    logic              r_done;
    flba_pkg::t_result r_result;

    // execute-stage decisions
    flba_pkg::t_status exe_status;
    logic [IW-1:0]     exe_granted;
    logic              exe_wr;
    logic              exe_wr_busy;
    logic [IW-1:0]     exe_wr_addr;
    logic [IW-1:0]     exe_wr_link;

    flba_pkg::t_mem_req mem_req;
    logic               rd_busy;
    logic [IW-1:0]      rd_link;
    logic               accept;
    logic               idx_foreign;

    assign accept      = start && !busy;
    assign idx_foreign = (i_req.node_index >= IW'(CAPACITY));

    flba_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_busy (rd_busy),
        .o_rd_link (rd_link)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            flba_pkg::ST_INIT: begin
                if (r_init_addr == AW'(CAPACITY - 1)) begin
                    n_state = flba_pkg::ST_IDLE;
                end
            end
            flba_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = flba_pkg::ST_EXEC;
                end
            end
            flba_pkg::ST_EXEC: begin
                n_state = flba_pkg::ST_IDLE;
            end
            default: begin
                n_state = flba_pkg::ST_INIT;
            end
        endcase
    end

    // pop / push decision on the slot word read back from memory
    always_comb begin
        exe_status  = flba_pkg::STATUS_OK;
        exe_granted = '0;
        exe_wr      = 1'b0;
        exe_wr_busy = 1'b0;
        exe_wr_addr = '0;
        exe_wr_link = '0;
        n_head      = r_head;
        n_count     = r_count;
        if (r_op == flba_pkg::OP_ACQUIRE) begin
            if (r_count == '0) begin
                exe_status = flba_pkg::STATUS_EMPTY;
            end else begin
                // pop: head slot goes in use, its link becomes the new head
                exe_granted = IW'(r_head);
                exe_wr      = 1'b1;
                exe_wr_busy = 1'b1;
                exe_wr_addr = IW'(r_head);
                exe_wr_link = '0;
                n_head      = rd_link[AW-1:0];
                n_count     = r_count - CW'(1);
            end
        end else begin
            if (r_idx >= IW'(CAPACITY)) begin
                exe_status = flba_pkg::STATUS_FOREIGN;
            end else if (!rd_busy) begin
                exe_status = flba_pkg::STATUS_IDLE;
            end else begin
                // push: released slot links to the old head
                exe_wr      = 1'b1;
                exe_wr_busy = 1'b0;
                exe_wr_addr = r_idx;
                exe_wr_link = IW'(r_head);
                n_head      = r_idx[AW-1:0];
                n_count     = r_count + CW'(1);
            end
        end
    end

    // state-dependent outputs and memory access
    always_comb begin
        busy    = 1'b1;
        mem_req = '0;
        unique case (r_state)
            flba_pkg::ST_INIT: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = IW'(r_init_addr);
                mem_req.wr_busy = 1'b0;
                mem_req.wr_link = (r_init_addr == '0) ? '0 : IW'(r_init_addr - AW'(1));
            end
            flba_pkg::ST_IDLE: begin
                busy          = 1'b0;
                mem_req.rd_en = accept;
                // release reads its own slot, acquire reads the head slot
                if (i_req.op == flba_pkg::OP_RELEASE) begin
                    mem_req.rd_addr = idx_foreign ? '0 : i_req.node_index;
                end else begin
                    mem_req.rd_addr = IW'(r_head);
                end
            end
            flba_pkg::ST_EXEC: begin
                mem_req.wr_en   = exe_wr;
                mem_req.wr_addr = exe_wr_addr;
                mem_req.wr_busy = exe_wr_busy;
                mem_req.wr_link = exe_wr_link;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= flba_pkg::ST_INIT;
            r_init_addr <= '0;
            r_head      <= AW'(CAPACITY - 1);
            r_count     <= CW'(CAPACITY);
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == flba_pkg::ST_EXEC);
            if (r_state == flba_pkg::ST_INIT) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (r_state == flba_pkg::ST_EXEC) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    // transaction capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_req.op;
            r_idx <= i_req.node_index;
        end
        if (r_state == flba_pkg::ST_EXEC) begin
            r_result.status        <= exe_status;
            r_result.granted_index <= exe_granted;
            r_result.free_count    <= IW'(n_count);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    // a result only follows an execute cycle
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == flba_pkg::ST_EXEC))
        else $error("result strobe without execute cycle");

    // an accepted transaction always executes in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == flba_pkg::ST_EXEC))
        else $error("accepted transaction did not execute");

    // free count never exceeds the pool
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("free count above capacity");

    // empty status only with no free slot
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == flba_pkg::STATUS_EMPTY) |-> (o_result.free_count == '0))
        else $error("empty status with free slots left");
`endif

endmodule

// ===== tb/free_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// free_list_checker
// Watches the allocator's command and result channels against a local model.
// ----------------------------------------------------------------------------
// Keeps its own copy of the slot links, in-use marks, head and free count.
// Every accepted transaction produces one expected result, queued in order.
// Every strobed result is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module free_list_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  flba_pkg::t_request i_req,
    input  logic               i_done,
    input  flba_pkg::t_result  i_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int unsigned IDX_W = flba_pkg::IDX_W;
    localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [IDX_W-1:0] slot_link  [CAPACITY];
    logic             slot_taken [CAPACITY];
    logic [IDX_W-1:0] list_head;
    logic [IDX_W-1:0] free_slots;

    flba_pkg::t_result expected_results [$];
    int                fails = 0;

    task automatic rebuild_pool();
        for (int i = 0; i < CAPACITY; i++) begin
            slot_link[i]  = (i == 0) ? '0 : IDX_W'(i - 1);
            slot_taken[i] = 1'b0;
        end
        list_head  = IDX_W'(CAPACITY - 1);
        free_slots = IDX_W'(CAPACITY);
    endtask

    // one transaction through the model, state updated in place
    function automatic flba_pkg::t_result allocate_or_free(flba_pkg::t_request req);
        flba_pkg::t_result r;
        logic [AW-1:0]     slot;
        r.status        = flba_pkg::STATUS_OK;
        r.granted_index = '0;
        if (req.op == flba_pkg::OP_ACQUIRE) begin
            if (free_slots == '0) begin
                r.status = flba_pkg::STATUS_EMPTY;
            end else begin
                slot             = list_head[AW-1:0];
                r.granted_index  = list_head;
                list_head        = slot_link[slot];
                slot_link[slot]  = '0;
                slot_taken[slot] = 1'b1;
                free_slots       = free_slots - IDX_W'(1);
            end
        end else if (req.node_index >= IDX_W'(CAPACITY)) begin
            r.status = flba_pkg::STATUS_FOREIGN;
        end else if (!slot_taken[req.node_index[AW-1:0]]) begin
            r.status = flba_pkg::STATUS_IDLE;
        end else begin
            slot             = req.node_index[AW-1:0];
            slot_taken[slot] = 1'b0;
            slot_link[slot]  = list_head;
            list_head        = req.node_index;
            free_slots       = free_slots + IDX_W'(1);
        end
        r.free_count = free_slots;
        return r;
    endfunction

    task automatic check_field(string field, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        flba_pkg::t_result want;
        if (!i_rst_n) begin
            rebuild_pool();
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d",
                             $time, i_result.status);
                    $display("%0t: unexpected result granted %0d free %0d",
                             $time, i_result.granted_index, i_result.free_count);
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", IDX_W'(want.status), IDX_W'(i_result.status));
                    check_field("granted_index", want.granted_index, i_result.granted_index);
                    check_field("free_count", want.free_count, i_result.free_count);
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(allocate_or_free(i_req));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_free_list_buffer_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_free_list_buffer_allocator
// Stimulus and verdict for the free-list buffer allocator.
// ----------------------------------------------------------------------------
// A short directed sequence hits foreign and idle releases, reuse of a freed
// slot and the list order. Random phases then drain the pool to empty, refill
// it and mix both, mostly releasing slots that are really held, with some
// idle and foreign releases as noise. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_free_list_buffer_allocator;

    localparam int unsigned IDX_W        = flba_pkg::IDX_W;
    localparam int unsigned CAPACITY     = 64;
    localparam int          RANDOM_ITEMS = 850;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    flba_pkg::t_request i_req   = '0;
    logic               busy;
    logic               o_done;
    flba_pkg::t_result  o_result;

    int       fail_count;
    int       pending;

    // ops in flight, to tell acquire grants from release acks
    flba_pkg::t_op    ops_in_flight [$];
    // slots this side believes are held, source of well-formed releases
    logic [IDX_W-1:0] held_slots [$];

    int n_acquire = 0;
    int n_release = 0;
    int n_empty   = 0;
    int n_foreign = 0;
    int n_idle    = 0;
    int cycles    = 0;

    free_list_buffer_allocator #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    free_list_checker #(
        .CAPACITY (CAPACITY)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog over the whole run, covers the sweep after reset too
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // follow results to learn which slots are held
    always @(posedge i_clk) begin
        flba_pkg::t_op op;
        if (i_rst_n && o_done && ops_in_flight.size() > 0) begin
            op = ops_in_flight.pop_front();
            if (op == flba_pkg::OP_ACQUIRE) begin
                n_acquire++;
                if (o_result.status == flba_pkg::STATUS_OK)
                    held_slots.push_back(o_result.granted_index);
            end else begin
                n_release++;
            end
            case (o_result.status)
                flba_pkg::STATUS_EMPTY:   n_empty++;
                flba_pkg::STATUS_FOREIGN: n_foreign++;
                flba_pkg::STATUS_IDLE:    n_idle++;
                default: begin
                end
            endcase
        end
    end

    // mostly back-to-back, some short pauses, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // present one transaction and hold it until taken; start stays high when
    // no gap follows so the next transaction can go back-to-back
    task automatic send_txn(flba_pkg::t_op op, logic [IDX_W-1:0] idx, int gap);
        start          <= 1'b1;
        i_req.op       <= op;
        i_req.node_index <= idx;
        do @(posedge i_clk); while (busy);
        ops_in_flight.push_back(op);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_quiet();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || ops_in_flight.size() != 0);
    endtask

    // release target: a held slot most of the time, else idle or foreign noise
    function automatic logic [IDX_W-1:0] pick_release_slot();
        int k;
        logic [IDX_W-1:0] idx;
        if (held_slots.size() > 0 && $urandom_range(0, 99) < 75) begin
            k   = $urandom_range(0, held_slots.size() - 1);
            idx = held_slots[k];
            held_slots.delete(k);
        end else if ($urandom_range(0, 1) == 0) begin
            idx = IDX_W'($urandom_range(0, CAPACITY - 1));
        end else begin
            idx = IDX_W'($urandom_range(CAPACITY, 1023));
        end
        return idx;
    endfunction

    initial begin
        int sent;
        int kind;
        int phase_len;
        int no_gaps;
        int acq_pct;
        flba_pkg::t_op op;
        logic [IDX_W-1:0] idx;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: nothing held yet, so releases are idle or foreign
        send_txn(flba_pkg::OP_RELEASE, 10'd0, pick_gap());
        send_txn(flba_pkg::OP_RELEASE, 10'd63, pick_gap());
        send_txn(flba_pkg::OP_RELEASE, 10'd64, pick_gap());
        send_txn(flba_pkg::OP_RELEASE, 10'd1023, pick_gap());
        send_txn(flba_pkg::OP_RELEASE, 10'h2aa, pick_gap());
        // pops come off the top of the initial list, index field ignored
        send_txn(flba_pkg::OP_ACQUIRE, 10'd1023, 0);
        send_txn(flba_pkg::OP_ACQUIRE, 10'd0, 0);
        send_txn(flba_pkg::OP_ACQUIRE, 10'h155, 0);
        // free the middle one twice, second time it is idle
        send_txn(flba_pkg::OP_RELEASE, 10'd62, 0);
        send_txn(flba_pkg::OP_RELEASE, 10'd62, pick_gap());
        // freed slot comes straight back, then the lifo order is shuffled
        send_txn(flba_pkg::OP_ACQUIRE, 10'd0, 0);
        send_txn(flba_pkg::OP_RELEASE, 10'd63, 0);
        send_txn(flba_pkg::OP_RELEASE, 10'd61, 0);
        send_txn(flba_pkg::OP_RELEASE, 10'd62, 0);
        send_txn(flba_pkg::OP_ACQUIRE, 10'd0, 0);
        send_txn(flba_pkg::OP_ACQUIRE, 10'd0, 0);
        send_txn(flba_pkg::OP_ACQUIRE, 10'd0, 0);
        send_txn(flba_pkg::OP_RELEASE, 10'd61, pick_gap());
        send_txn(flba_pkg::OP_RELEASE, 10'd60, 0);
        wait_quiet();

        // first random phase empties the pool, back-to-back, past empty
        for (int i = 0; i < CAPACITY + 6; i++)
            send_txn(flba_pkg::OP_ACQUIRE, IDX_W'($urandom_range(0, 1023)), 0);
        sent = CAPACITY + 6;
        wait_quiet();

        while (sent < RANDOM_ITEMS) begin
            kind      = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 90);
            no_gaps   = ($urandom_range(0, 3) == 0);
            case (kind)
                0:       acq_pct = 90;
                1:       acq_pct = 10;
                default: acq_pct = 50;
            endcase
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                if ($urandom_range(0, 99) < acq_pct) begin
                    op  = flba_pkg::OP_ACQUIRE;
                    idx = IDX_W'($urandom_range(0, 1023));
                end else begin
                    op  = flba_pkg::OP_RELEASE;
                    idx = pick_release_slot();
                end
                send_txn(op, idx, no_gaps ? 0 : pick_gap());
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_quiet();
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d transactions: %0d acquires, %0d releases", n_acquire + n_release,
                 n_acquire, n_release);
        $display("outcomes: %0d empty pool, %0d foreign slot, %0d idle slot", n_empty,
                 n_foreign, n_idle);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
